>>> hw/rtl/sbfp_pkg.sv
// Shared types, codes and constants of the SPI bus block.
// It has no dependencies. The front, back and top level files import it.
package sbfp_pkg;

  localparam int unsigned FlashBytesDef = 262144;
  localparam int unsigned LenW          = 19;

  localparam logic [LenW-1:0] LENGTH_RESET = 19'h40000;

  typedef enum logic [1:0] {
    KIND_CTRL  = 2'd0,
    KIND_WDATA = 2'd1,
    KIND_RDATA = 2'd2,
    KIND_LOAD  = 2'd3
  } kind_e;

  typedef enum logic {
    ST_RUN = 1'b0,
    ST_MEM = 1'b1
  } back_state_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] value;
    logic [17:0] load_address;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } front_out_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_request;
  } result_t;

  localparam logic [15:0] CTRL_MASK = 16'hCF03;
  localparam logic [15:0] CTRL_KEEP = 16'h0080;

  localparam int unsigned CtrlEnable = 15;
  localparam int unsigned CtrlIrqEn  = 14;
  localparam int unsigned CtrlHold   = 11;

  localparam logic [1:0] DEV_POWER = 2'd0;
  localparam logic [1:0] DEV_FLASH = 2'd1;

  localparam logic [7:0] CMD_READ = 8'h03;
  localparam logic [7:0] CMD_WRDI = 8'h04;
  localparam logic [7:0] CMD_RDSR = 8'h05;
  localparam logic [7:0] CMD_WREN = 8'h06;
  localparam logic [7:0] CMD_RDID = 8'h9F;

  localparam logic [7:0] ID_BYTE0 = 8'h20;
  localparam logic [7:0] ID_BYTE1 = 8'h40;
  localparam logic [7:0] ID_BYTE2 = 8'h12;

  localparam logic [7:0] STATUS_WEL = 8'h02;

  localparam logic [2:0] POS_ADDR0 = 3'd1;
  localparam logic [2:0] POS_ADDR1 = 3'd2;
  localparam logic [2:0] POS_ADDR2 = 3'd3;
  localparam logic [2:0] POS_DATA  = 3'd4;

  localparam logic [7:0] POWER_REG4_RESET = 8'h40;

  function automatic logic [7:0] power_mask(input logic [2:0] sel);
    logic [7:0] m;
    case (sel)
      3'd0:    m = 8'h7F;
      3'd1:    m = 8'h01;
      3'd2:    m = 8'h01;
      3'd3:    m = 8'h03;
      3'd4:    m = 8'h0F;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

>>> hw/rtl/sbfp_front.sv
// Front end: two-word input queue that takes words from the push side.
// Depends on sbfp_pkg for the word and front output types.
module sbfp_front import sbfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  item_t      item_i,
  output front_out_t front_o,
  input  logic       take_i
);

  item_t      slot_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_take;

  assign full    = (count_q == 2'd2);
  assign do_push = push && !full;
  assign do_take = take_i && (count_q != 2'd0);

  assign front_o.valid = (count_q != 2'd0);
  assign front_o.item  = slot_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q ^ do_push;
    rptr_d  = rptr_q ^ do_take;
    count_d = count_q + {1'b0, do_push} - {1'b0, do_take};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

endmodule

>>> hw/rtl/sbfp_back.sv
// Back end: control word, flash and power manager models, flash memory
// and the two-word result queue. Depends on sbfp_pkg.
module sbfp_back import sbfp_pkg::*; #(
  parameter int unsigned FLASH_BYTES = FlashBytesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  front_out_t      front_i,
  output logic            take_o,
  input  logic [LenW-1:0] flash_length_i,
  output logic            empty,
  input  logic            pop,
  output result_t         result_o
);

  localparam int unsigned AW = $clog2(FLASH_BYTES);

  logic [7:0] mem [FLASH_BYTES];
  logic [7:0] mem_rdata_q;

  back_state_e state_q, state_d;
  logic [15:0] ctrl_q, ctrl_d;
  logic        fhold_q, fhold_d;
  logic [7:0]  fcmd_q, fcmd_d;
  logic [2:0]  fpos_q, fpos_d;
  logic [31:0] fptr_q, fptr_d;
  logic [7:0]  fout_q, fout_d;
  logic [7:0]  fstat_q, fstat_d;
  logic        phold_q, phold_d;
  logic [7:0]  pidx_q, pidx_d;
  logic        pfirst_q, pfirst_d;
  logic [7:0]  pout_q, pout_d;
  logic [7:0]  pregs_q [8];
  logic [7:0]  pregs_d [8];

  result_t    oq_q [2];
  logic       owptr_q, orptr_q;
  logic [1:0] ocount_q;

  logic       go, enabled, hold, mem_re, mem_we;
  logic [1:0] dev;
  logic [7:0] b, pm;
  logic [2:0] psel_idx;
  logic [31:0] load_addr;
  logic [31:0] len_ext;
  result_t    res;
  logic       do_pop;

  assign enabled   = ctrl_q[CtrlEnable];
  assign hold      = ctrl_q[CtrlHold];
  assign dev       = ctrl_q[9:8];
  assign b         = front_i.item.value[7:0];
  assign psel_idx  = pidx_q[2:0];
  assign pm        = power_mask(psel_idx);
  assign load_addr = 32'(front_i.item.load_address);
  assign len_ext   = 32'(flash_length_i);

  assign go     = (state_q == ST_RUN) && front_i.valid && (ocount_q != 2'd2);
  assign take_o = go;

  always_comb begin
    state_d  = state_q;
    ctrl_d   = ctrl_q;
    fhold_d  = fhold_q;
    fcmd_d   = fcmd_q;
    fpos_d   = fpos_q;
    fptr_d   = fptr_q;
    fout_d   = fout_q;
    fstat_d  = fstat_q;
    phold_d  = phold_q;
    pidx_d   = pidx_q;
    pfirst_d = pfirst_q;
    pout_d   = pout_q;
    pregs_d  = pregs_q;
    mem_re   = 1'b0;
    mem_we   = 1'b0;
    res      = '0;
    unique case (state_q)
      ST_MEM: begin
        fout_d  = mem_rdata_q;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (go) begin
          unique case (front_i.item.kind)
            KIND_CTRL: begin
              ctrl_d = (ctrl_q & CTRL_KEEP) | (front_i.item.value & CTRL_MASK);
            end
            KIND_WDATA: begin
              if (enabled) begin
                res.irq_request = ctrl_q[CtrlIrqEn];
                if (dev == DEV_FLASH) begin
                  fhold_d = hold ? fhold_q : 1'b0;
                  if (hold && !fhold_q) begin
                    fcmd_d  = b;
                    fhold_d = 1'b1;
                    fout_d  = 8'h00;
                    fpos_d  = POS_ADDR0;
                    fptr_d  = '0;
                  end else begin
                    case (fcmd_q)
                      CMD_READ: begin
                        if (fpos_q < POS_DATA) begin
                          fptr_d = {fptr_q[23:0], b};
                          fout_d = 8'h00;
                          fpos_d = fpos_q + 3'd1;
                        end else begin
                          if (fptr_q >= len_ext || fptr_q >= 32'(FLASH_BYTES)) begin
                            fout_d = 8'h00;
                          end else begin
                            mem_re  = 1'b1;
                            state_d = ST_MEM;
                          end
                          fptr_d = fptr_q + 32'd1;
                        end
                      end
                      CMD_WRDI: begin
                        fstat_d = fstat_q & ~STATUS_WEL;
                        fout_d  = 8'h00;
                      end
                      CMD_RDSR: fout_d = fstat_q;
                      CMD_WREN: begin
                        fstat_d = fstat_q | STATUS_WEL;
                        fout_d  = 8'h00;
                      end
                      CMD_RDID: begin
                        case (fpos_q)
                          POS_ADDR0: fout_d = ID_BYTE0;
                          POS_ADDR1: fout_d = ID_BYTE1;
                          POS_ADDR2: fout_d = ID_BYTE2;
                          default:   fout_d = 8'h00;
                        endcase
                        if (fpos_q < POS_DATA) begin
                          fpos_d = fpos_q + 3'd1;
                        end
                      end
                      default: ;
                    endcase
                  end
                end else if (dev == DEV_POWER) begin
                  phold_d = hold ? phold_q : 1'b0;
                  if (hold && !phold_q) begin
                    pidx_d   = b;
                    phold_d  = 1'b1;
                    pout_d   = 8'h00;
                    pfirst_d = 1'b0;
                  end else if (!pfirst_q) begin
                    if (pidx_q[7]) begin
                      pout_d = pregs_q[psel_idx];
                    end else begin
                      pregs_d[psel_idx] = (pregs_q[psel_idx] & ~pm) | (b & pm);
                    end
                    pfirst_d = 1'b1;
                  end else begin
                    pout_d = 8'h00;
                  end
                end
              end
            end
            KIND_RDATA: begin
              if (enabled) begin
                if (dev == DEV_POWER) begin
                  res.read_data = pout_q;
                end else if (dev == DEV_FLASH) begin
                  res.read_data = fout_q;
                end
              end
            end
            KIND_LOAD: begin
              mem_we = (load_addr < 32'(FLASH_BYTES));
            end
            default: ;
          endcase
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[load_addr[AW-1:0]] <= b;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[fptr_q[AW-1:0]];
    end
  end

  // Result queue: push on every executed word, drain on pop.
  assign do_pop   = pop && (ocount_q != 2'd0);
  assign empty    = (ocount_q == 2'd0);
  assign result_o = oq_q[orptr_q];

  always_ff @(posedge clk_i) begin
    if (go) begin
      oq_q[owptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_RUN;
      ctrl_q   <= '0;
      fhold_q  <= 1'b0;
      fcmd_q   <= '0;
      fpos_q   <= '0;
      fptr_q   <= '0;
      fout_q   <= '0;
      fstat_q  <= '0;
      phold_q  <= 1'b0;
      pidx_q   <= '0;
      pfirst_q <= 1'b0;
      pout_q   <= '0;
      for (int i = 0; i < 8; i++) begin
        pregs_q[i] <= (i == 4) ? POWER_REG4_RESET : 8'h00;
      end
      owptr_q  <= 1'b0;
      orptr_q  <= 1'b0;
      ocount_q <= 2'd0;
    end else begin
      state_q  <= state_d;
      ctrl_q   <= ctrl_d;
      fhold_q  <= fhold_d;
      fcmd_q   <= fcmd_d;
      fpos_q   <= fpos_d;
      fptr_q   <= fptr_d;
      fout_q   <= fout_d;
      fstat_q  <= fstat_d;
      phold_q  <= phold_d;
      pidx_q   <= pidx_d;
      pfirst_q <= pfirst_d;
      pout_q   <= pout_d;
      pregs_q  <= pregs_d;
      owptr_q  <= owptr_q ^ go;
      orptr_q  <= orptr_q ^ do_pop;
      ocount_q <= ocount_q + {1'b0, go} - {1'b0, do_pop};
    end
  end

  a_oq_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocount_q != 2'd3) else $error("result queue overflow");

  a_mem_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MEM |=> state_q == ST_RUN) else $error("memory wait too long");

  a_mem_from_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MEM |-> $past(go) && $past(fcmd_q) == CMD_READ)
    else $error("memory wait without flash read");

  a_no_take_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MEM |-> !take_o) else $error("word taken during memory wait");

endmodule

>>> hw/rtl/spi_bus_with_flash_and_power_regs.sv
// Top level of the SPI bus block: APB register for the flash length,
// front queue and back end. Depends on sbfp_pkg, sbfp_front, sbfp_back.
//
// Usage: words enter through push/full (kind, value, load_address) and
// each yields one result word (read_data, irq_request) on empty/pop, in
// order. A word is taken at an edge with push high and full low; the oldest
// result is shown while empty is low and leaves on pop.
// On an idle block a taken word waits in the front queue, then its result
// is written to the result queue and shown there.
// Throughput: one word per cycle while the result queue has room, except a
// flash data-phase read byte inside the flash length, which holds the back
// end in a memory wait state for the registered flash memory read port.
// A two-word result queue parts the back end from the receiver: with pop
// low it fills, then the back end halts, the input queue fills and full
// rises. No word is lost or repeated.
// Reset clears control word, device state (power register 4 to 0x40) and
// both queues; the flash length register returns to 262144. Flash memory
// contents are not cleared and must be preloaded before they are read.
// The APB port has one register, flash_length, at address 0; pready is
// always high. Write it only while the block is idle.
module spi_bus_with_flash_and_power_regs import sbfp_pkg::*; #(
  parameter int unsigned FLASH_BYTES = FlashBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind_i,
  input  logic [15:0] value_i,
  input  logic [17:0] load_address_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  read_data_o,
  output logic        irq_request_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [LenW-1:0] flen_q, flen_d;
  logic            cfg_we;
  item_t           item;
  front_out_t      front;
  logic            take;
  result_t         res;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? 32'(flen_q) : 32'h0;

  always_comb begin
    flen_d = cfg_we ? pwdata[LenW-1:0] : flen_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flen_q <= LENGTH_RESET;
    end else begin
      flen_q <= flen_d;
    end
  end

  assign item.kind         = kind_e'(kind_i);
  assign item.value        = value_i;
  assign item.load_address = load_address_i;

  sbfp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (item),
    .front_o (front),
    .take_i  (take)
  );

  sbfp_back #(
    .FLASH_BYTES (FLASH_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .front_i        (front),
    .take_o         (take),
    .flash_length_i (flen_q),
    .empty          (empty),
    .pop            (pop),
    .result_o       (res)
  );

  assign read_data_o   = res.read_data;
  assign irq_request_o = res.irq_request;

endmodule
